/* sv/dfl_pkg.sv */
package dfl_pkg;

    // slot status codes
    localparam logic [1:0] ST_EMPTY  = 2'd0;
    localparam logic [1:0] ST_PEND_A = 2'd1;
    localparam logic [1:0] ST_PEND_B = 2'd2;
    localparam logic [1:0] ST_DONE   = 2'd3;

    // winner codes
    localparam logic [1:0] WIN_NONE = 2'd0;
    localparam logic [1:0] WIN_A    = 2'd1;
    localparam logic [1:0] WIN_B    = 2'd2;
    localparam logic [1:0] WIN_TIE  = 2'd3;

    localparam logic [62:0] MAX_ADV = '1;

    typedef struct packed {
        logic        side;
        logic [63:0] sequence_number;
        logic [63:0] timestamp_ns;
    } t_in_item;

    typedef struct packed {
        logic        matched;
        logic [1:0]  winner;
        logic [62:0] advantage_ns;
        logic [63:0] packets_a;
        logic [63:0] packets_b;
        logic [63:0] unmatched_a;
        logic [63:0] unmatched_b;
        logic [63:0] faster_a;
        logic [63:0] faster_b;
        logic [63:0] sum_advantage_a;
        logic [63:0] sum_advantage_b;
        logic [63:0] sum_advantage_all;
    } t_out_item;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_ACCUM,
        S_SUM
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clear_wr;
        logic capture;
        logic eval;
        logic accum;
        logic load_out;
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
    } t_ctrl_sts;

endpackage

/* sv/dfl_ctrl.sv */
module dfl_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  dfl_pkg::t_ctrl_sts   i_sts,
    output logic                 busy,
    output logic                 o_valid,
    output dfl_pkg::t_ctrl_cmd   o_cmd
);

    dfl_pkg::t_state r_state;
    dfl_pkg::t_state n_state;
    logic            r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dfl_pkg::S_CLEAR;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == dfl_pkg::S_SUM);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            dfl_pkg::S_CLEAR: begin
                if (i_sts.clear_last) n_state = dfl_pkg::S_IDLE;
            end
            dfl_pkg::S_IDLE: begin
                if (start) n_state = dfl_pkg::S_LOOK;
            end
            dfl_pkg::S_LOOK:  n_state = dfl_pkg::S_ACCUM;
            dfl_pkg::S_ACCUM: n_state = dfl_pkg::S_SUM;
            dfl_pkg::S_SUM:   n_state = dfl_pkg::S_IDLE;
            default:          n_state = dfl_pkg::S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        case (r_state)
            dfl_pkg::S_CLEAR: o_cmd.clear_wr = 1'b1;
            dfl_pkg::S_IDLE: begin
                busy        = 1'b0;
                o_cmd.capture = start;
            end
            dfl_pkg::S_LOOK:  o_cmd.eval     = 1'b1;
            dfl_pkg::S_ACCUM: o_cmd.accum    = 1'b1;
            dfl_pkg::S_SUM:   o_cmd.load_out = 1'b1;
            default:          o_cmd = '0;
        endcase
    end

    assign o_valid = r_valid;

endmodule

/* sv/dfl_dpath.sv */
module dfl_dpath #(
    parameter int unsigned WINDOW_DEPTH = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dfl_pkg::t_in_item    i_item,
    input  dfl_pkg::t_ctrl_cmd   i_cmd,
    output dfl_pkg::t_ctrl_sts   o_sts,
    output dfl_pkg::t_out_item   o_result
);

    localparam int IDX_W = $clog2(WINDOW_DEPTH);
    localparam int TAG_W = 64 - IDX_W;
    localparam int ROW_W = 2 + TAG_W + 64;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic logic [63:0] sat_inc(input logic [63:0] a);
        return (&a) ? a : a + 64'd1;
    endfunction

    function automatic logic [63:0] dec_floor(input logic [63:0] a);
        return (a == '0) ? a : a - 64'd1;
    endfunction

    // window table: {status, tag, first time}
    logic [ROW_W-1:0] r_mem [WINDOW_DEPTH];
    logic [ROW_W-1:0] r_rd;
    logic [IDX_W-1:0] r_clr_addr;
    dfl_pkg::t_in_item r_item;

    // lookup decode
    logic [1:0]       rd_status;
    logic [TAG_W-1:0] rd_tag;
    logic [63:0]      rd_time;
    logic [IDX_W-1:0] idx_in;
    logic [IDX_W-1:0] idx_q;
    logic [TAG_W-1:0] item_tag;
    logic [1:0]       my_pend;
    logic [1:0]       other_pend;
    logic             hit;
    logic             n_match;
    logic             n_miss;
    logic [63:0]      ta;
    logic [63:0]      tb;
    logic             a_lt;
    logic             b_lt;
    logic [63:0]      diff;
    logic [62:0]      n_adv;
    logic [1:0]       n_winner;
    logic             wr_en;
    logic [ROW_W-1:0] wr_row;

    logic             r_match;
    logic             r_miss;
    logic [1:0]       r_winner;
    logic [62:0]      r_adv;

    // running counters
    logic [63:0] r_pkt_a, r_pkt_b, r_unm_a, r_unm_b;
    logic [63:0] r_fast_a, r_fast_b, r_tot_a, r_tot_b;

    dfl_pkg::t_out_item r_out;

    assign idx_in    = i_item.sequence_number[IDX_W-1:0];
    assign idx_q     = r_item.sequence_number[IDX_W-1:0];
    assign item_tag  = r_item.sequence_number[63:IDX_W];
    assign rd_status = r_rd[ROW_W-1 -: 2];
    assign rd_tag    = r_rd[64 +: TAG_W];
    assign rd_time   = r_rd[63:0];

    always_comb begin
        my_pend    = r_item.side ? dfl_pkg::ST_PEND_B : dfl_pkg::ST_PEND_A;
        other_pend = r_item.side ? dfl_pkg::ST_PEND_A : dfl_pkg::ST_PEND_B;
        hit        = (rd_status != dfl_pkg::ST_EMPTY) && (rd_tag == item_tag);
        n_match    = hit && (rd_status == other_pend);
        n_miss     = !hit;
        ta         = r_item.side ? rd_time : r_item.timestamp_ns;
        tb         = r_item.side ? r_item.timestamp_ns : rd_time;
        a_lt       = ta < tb;
        b_lt       = tb < ta;
        diff       = a_lt ? (tb - ta) : (ta - tb);
        n_adv      = '0;
        n_winner   = dfl_pkg::WIN_NONE;
        if (n_match) begin
            n_adv    = diff[63] ? dfl_pkg::MAX_ADV : diff[62:0];
            n_winner = a_lt ? dfl_pkg::WIN_A : (b_lt ? dfl_pkg::WIN_B : dfl_pkg::WIN_TIE);
        end
        wr_en  = i_cmd.eval && (n_match || n_miss);
        wr_row = n_match ? {dfl_pkg::ST_DONE, rd_tag, rd_time}
                         : {my_pend, item_tag, r_item.timestamp_ns};
    end

    // table port: one write and one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_wr) begin
            r_mem[r_clr_addr] <= '0;
        end else if (wr_en) begin
            r_mem[idx_q] <= wr_row;
        end
        if (i_cmd.capture) begin
            r_rd <= r_mem[idx_in];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) r_item <= i_item;
        if (i_cmd.eval) begin
            r_match  <= n_match;
            r_miss   <= n_miss;
            r_winner <= n_winner;
            r_adv    <= n_adv;
        end
        if (i_cmd.load_out) begin
            r_out.matched           <= r_match;
            r_out.winner            <= r_winner;
            r_out.advantage_ns      <= r_adv;
            r_out.packets_a         <= r_pkt_a;
            r_out.packets_b         <= r_pkt_b;
            r_out.unmatched_a       <= r_unm_a;
            r_out.unmatched_b       <= r_unm_b;
            r_out.faster_a          <= r_fast_a;
            r_out.faster_b          <= r_fast_b;
            r_out.sum_advantage_a   <= r_tot_a;
            r_out.sum_advantage_b   <= r_tot_b;
            r_out.sum_advantage_all <= sat_add(r_tot_a, r_tot_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_pkt_a    <= '0;
            r_pkt_b    <= '0;
            r_unm_a    <= '0;
            r_unm_b    <= '0;
            r_fast_a   <= '0;
            r_fast_b   <= '0;
            r_tot_a    <= '0;
            r_tot_b    <= '0;
        end else begin
            if (i_cmd.clear_wr) r_clr_addr <= r_clr_addr + 1'b1;
            if (i_cmd.accum) begin
                if (r_item.side) begin
                    r_pkt_b <= sat_inc(r_pkt_b);
                    if (r_miss)  r_unm_b <= sat_inc(r_unm_b);
                    if (r_match) r_unm_a <= dec_floor(r_unm_a);
                end else begin
                    r_pkt_a <= sat_inc(r_pkt_a);
                    if (r_miss)  r_unm_a <= sat_inc(r_unm_a);
                    if (r_match) r_unm_b <= dec_floor(r_unm_b);
                end
                if (r_winner == dfl_pkg::WIN_A) begin
                    r_fast_a <= sat_inc(r_fast_a);
                    r_tot_a  <= sat_add(r_tot_a, {1'b0, r_adv});
                end
                if (r_winner == dfl_pkg::WIN_B) begin
                    r_fast_b <= sat_inc(r_fast_b);
                    r_tot_b  <= sat_add(r_tot_b, {1'b0, r_adv});
                end
            end
        end
    end

    assign o_sts.clear_last = &r_clr_addr;
    assign o_result         = r_out;

endmodule

/* sv/dual_feed_latency_matcher.sv */
// dual-feed latency matcher
// input: one packet beat per start pulse, taken when start is high and busy
// is low; the beat carries the feed side, sequence number and timestamp
// output: one result beat per packet, shown on o_result for exactly one
// cycle with o_valid high; the receiver has no way to stall it
// after the accepting edge the sequencer steps through the read, evaluate,
// count and sum states around the window table, and o_valid is registered
// from the sum state; no new packet is taken until the sum state is done
// the window table is direct mapped, indexed by the low sequence bits;
// WINDOW_DEPTH must be a power of two
// reset: counters clear at once, then a clearing pass writes every table
// slot empty, one slot per cycle, with busy held high
// counters and sums saturate; software divides sums by counts for averages
module dual_feed_latency_matcher #(
    parameter int unsigned WINDOW_DEPTH = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  dfl_pkg::t_in_item   i_item,
    output logic                busy,
    output logic                o_valid,
    output dfl_pkg::t_out_item  o_result
);

    // command and status between sequencer and datapath
    dfl_pkg::t_ctrl_cmd cmd;
    dfl_pkg::t_ctrl_sts sts;

    // sequencer: clear pass, then lookup, evaluate, accumulate, publish
    dfl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (sts),
        .busy    (busy),
        .o_valid (o_valid),
        .o_cmd   (cmd)
    );

    // datapath: window table, pair compare, running counters, result register
    dfl_dpath #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_result (o_result)
    );

endmodule

/* tb/tb_dual_feed_latency_matcher.sv */
`timescale 1ns / 1ps

module tb_dual_feed_latency_matcher;

    import dfl_pkg::*;

    // table geometry mirrors the block's default window
    localparam int unsigned DEPTH = 1024;
    localparam int unsigned IDX_W = $clog2(DEPTH);
    localparam int unsigned LIMIT_CYCLES = 400000;
    localparam int unsigned RANDOM_ITEMS = 1924;
    localparam int unsigned DRAIN_CYCLES = 16;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    t_in_item    i_item = '0;
    logic        busy;
    logic        o_valid;
    t_out_item   o_result;

    dual_feed_latency_matcher #(
        .WINDOW_DEPTH(DEPTH)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_item  (i_item),
        .busy    (busy),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // matcher shadow: window table plus running counters
    // ------------------------------------------------------------------
    logic [1:0]        win_status [DEPTH];
    logic [63-IDX_W:0] win_tag    [DEPTH];
    logic [63:0]       win_time   [DEPTH];
    logic [63:0] pkts_a = '0, pkts_b = '0;
    logic [63:0] lone_a = '0, lone_b = '0;
    logic [63:0] wins_a = '0, wins_b = '0;
    logic [63:0] adv_sum_a = '0, adv_sum_b = '0;

    function automatic logic [63:0] sat_inc64(logic [63:0] v);
        return (v == '1) ? v : v + 64'd1;
    endfunction

    function automatic logic [63:0] sat_add64(logic [63:0] x, logic [63:0] y);
        logic [64:0] s;
        s = {1'b0, x} + {1'b0, y};
        return s[64] ? '1 : s[63:0];
    endfunction

    // advances the shadow by one packet and returns the report it must produce
    function automatic t_out_item match_packet(t_in_item pkt);
        logic [IDX_W-1:0]  idx;
        logic [63-IDX_W:0] tag;
        logic [1:0]        own_pend, other_pend;
        logic [63:0]       ta, tb, diff;
        t_out_item         rep;
        idx = pkt.sequence_number[IDX_W-1:0];
        tag = pkt.sequence_number[63:IDX_W];
        own_pend = pkt.side ? ST_PEND_B : ST_PEND_A;
        other_pend = pkt.side ? ST_PEND_A : ST_PEND_B;
        rep = '0;
        rep.winner = WIN_NONE;
        if (pkt.side) pkts_b = sat_inc64(pkts_b);
        else pkts_a = sat_inc64(pkts_a);
        if (win_status[idx] != ST_EMPTY && win_tag[idx] == tag) begin
            // same-side copy or completed sequence falls through untouched
            if (win_status[idx] == other_pend) begin
                ta = pkt.side ? win_time[idx] : pkt.timestamp_ns;
                tb = pkt.side ? pkt.timestamp_ns : win_time[idx];
                rep.matched = 1'b1;
                if (pkt.side) lone_a = (lone_a == '0) ? lone_a : lone_a - 64'd1;
                else lone_b = (lone_b == '0) ? lone_b : lone_b - 64'd1;
                diff = '0;
                if (ta < tb) begin
                    diff = tb - ta;
                end else if (tb < ta) begin
                    diff = ta - tb;
                end
                // huge gaps clip at the 63-bit ceiling
                if (diff > {1'b0, MAX_ADV}) diff = {1'b0, MAX_ADV};
                if (ta < tb) begin
                    rep.winner = WIN_A;
                    wins_a = sat_inc64(wins_a);
                    adv_sum_a = sat_add64(adv_sum_a, diff);
                end else if (tb < ta) begin
                    rep.winner = WIN_B;
                    wins_b = sat_inc64(wins_b);
                    adv_sum_b = sat_add64(adv_sum_b, diff);
                end else begin
                    rep.winner = WIN_TIE;
                end
                rep.advantage_ns = diff[62:0];
                win_status[idx] = ST_DONE;
            end
        end else begin
            // empty slot or a different tag: take the slot over
            win_status[idx] = own_pend;
            win_tag[idx] = tag;
            win_time[idx] = pkt.timestamp_ns;
            if (pkt.side) lone_b = sat_inc64(lone_b);
            else lone_a = sat_inc64(lone_a);
        end
        rep.packets_a = pkts_a;
        rep.packets_b = pkts_b;
        rep.unmatched_a = lone_a;
        rep.unmatched_b = lone_b;
        rep.faster_a = wins_a;
        rep.faster_b = wins_b;
        rep.sum_advantage_a = adv_sum_a;
        rep.sum_advantage_b = adv_sum_b;
        rep.sum_advantage_all = sat_add64(adv_sum_a, adv_sum_b);
        return rep;
    endfunction

    // ------------------------------------------------------------------
    // stimulus store and bookkeeping
    // ------------------------------------------------------------------
    t_in_item  packet_queue [$];
    t_out_item report_queue [$];
    t_in_item  open_seqs [$];
    t_in_item  done_seqs [$];

    int unsigned err_count = 0;
    int unsigned beat_count = 0;
    int unsigned report_count = 0;
    int unsigned pair_count = 0;
    int unsigned tie_count = 0;
    int unsigned clip_count = 0;
    int unsigned cycle_count = 0;
    int unsigned gap_left = 0;
    int unsigned burst_left = 0;
    bit          beat_taken = 1'b0;

    function automatic t_in_item mk_pkt(logic side, logic [63:0] seq, logic [63:0] ts);
        t_in_item p;
        p.side = side;
        p.sequence_number = seq;
        p.timestamp_ns = ts;
        return p;
    endfunction

    // mostly short gaps, a few long ones, and now and then a dense burst
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            burst_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    task automatic check_field(input string name, input logic [63:0] want_v,
                               input logic [63:0] got_v);
        if (got_v !== want_v) begin
            err_count++;
            $display("%0t ns: %s expected %h actual %h", $time, name, want_v, got_v);
        end
    endtask

    // ------------------------------------------------------------------
    // driver: inputs move on the falling edge only
    // ------------------------------------------------------------------
    t_in_item nxt_item;
    logic     nxt_start;

    always @(negedge i_clk) begin
        nxt_item = i_item;
        nxt_start = start;
        if (!i_rst_n) begin
            nxt_start = 1'b0;
        end else if (!start || beat_taken) begin
            beat_taken = 1'b0;
            nxt_start = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (packet_queue.size() > 0) begin
                nxt_item = packet_queue.pop_front();
                nxt_start = 1'b1;
                gap_left = pick_gap();
            end
        end
        // one nonblocking write per signal per step
        start <= nxt_start;
        i_item <= nxt_item;
    end

    // ------------------------------------------------------------------
    // monitor: results checked and beats taken at the rising edge
    // ------------------------------------------------------------------
    t_out_item want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (report_queue.size() == 0) begin
                err_count++;
                $display("%0t ns: result with nothing expected, actual %h", $time, o_result);
            end else begin
                want = report_queue.pop_front();
                report_count++;
                check_field("matched", 64'(want.matched), 64'(o_result.matched));
                check_field("winner", 64'(want.winner), 64'(o_result.winner));
                check_field("advantage_ns", 64'(want.advantage_ns),
                            64'(o_result.advantage_ns));
                check_field("packets_a", want.packets_a, o_result.packets_a);
                check_field("packets_b", want.packets_b, o_result.packets_b);
                check_field("unmatched_a", want.unmatched_a, o_result.unmatched_a);
                check_field("unmatched_b", want.unmatched_b, o_result.unmatched_b);
                check_field("faster_a", want.faster_a, o_result.faster_a);
                check_field("faster_b", want.faster_b, o_result.faster_b);
                check_field("sum_advantage_a", want.sum_advantage_a,
                            o_result.sum_advantage_a);
                check_field("sum_advantage_b", want.sum_advantage_b,
                            o_result.sum_advantage_b);
                check_field("sum_advantage_all", want.sum_advantage_all,
                            o_result.sum_advantage_all);
                if (want.matched) pair_count++;
                if (want.winner == WIN_TIE) tie_count++;
                if (want.advantage_ns == MAX_ADV) clip_count++;
            end
        end
        // a beat is taken when start meets a low busy
        if (i_rst_n && start && !busy) begin
            report_queue.push_back(match_packet(i_item));
            beat_taken = 1'b1;
            beat_count++;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("%0t ns: timeout with %0d results outstanding", $time,
                     report_queue.size());
            $display("FAIL dual_feed_latency_matcher");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus generation and end of run
    // ------------------------------------------------------------------
    t_in_item    pkt, first;
    int unsigned r, k;
    logic [63:0] seq, ts;

    initial begin
        for (int i = 0; i < DEPTH; i++) win_status[i] = ST_EMPTY;

        // directed: pairing, duplicates, completed copies
        packet_queue.push_back(mk_pkt(1'b0, 64'd0, 64'd100));
        packet_queue.push_back(mk_pkt(1'b0, 64'd0, 64'd200));
        packet_queue.push_back(mk_pkt(1'b1, 64'd0, 64'd150));
        packet_queue.push_back(mk_pkt(1'b1, 64'd0, 64'd0));
        packet_queue.push_back(mk_pkt(1'b0, 64'd0, 64'd5));
        // extreme sequence and timestamps, difference clipped
        packet_queue.push_back(mk_pkt(1'b1, '1, '1));
        packet_queue.push_back(mk_pkt(1'b0, '1, 64'd0));
        // tie
        packet_queue.push_back(mk_pkt(1'b1, 64'd1, 64'd7));
        packet_queue.push_back(mk_pkt(1'b0, 64'd1, 64'd7));
        // collisions evicting pending entries, then a b-side win
        packet_queue.push_back(mk_pkt(1'b0, 64'd2, 64'd10));
        packet_queue.push_back(mk_pkt(1'b1, 64'd2 + DEPTH, 64'd20));
        packet_queue.push_back(mk_pkt(1'b0, 64'd2, 64'd30));
        packet_queue.push_back(mk_pkt(1'b1, 64'd2, 64'd5));
        // evicting a completed entry lets the sequence pend again
        packet_queue.push_back(mk_pkt(1'b0, 64'd2 + 2 * DEPTH, 64'd1));
        packet_queue.push_back(mk_pkt(1'b0, 64'd2, 64'd40));
        packet_queue.push_back(mk_pkt(1'b1, 64'd2, 64'd41));

        // random: mostly well-formed pairs with duplicates and collisions mixed in
        while (packet_queue.size() < 16 + RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 45 && open_seqs.size() > 0) begin
                k = $urandom_range(0, open_seqs.size() - 1);
                first = open_seqs[k];
                open_seqs.delete(k);
                if ($urandom_range(0, 9) == 0) ts = first.timestamp_ns;
                else ts = first.timestamp_ns + 64'($urandom_range(0, 1 << 20))
                          - 64'($urandom_range(0, 1 << 20));
                pkt = mk_pkt(!first.side, first.sequence_number, ts);
                done_seqs.push_back(pkt);
                if (done_seqs.size() > 32) void'(done_seqs.pop_front());
            end else if (r < 60 && (open_seqs.size() + done_seqs.size()) > 0) begin
                ts = {$urandom, $urandom};
                if (done_seqs.size() == 0 || (open_seqs.size() > 0 && $urandom_range(0, 1))) begin
                    first = open_seqs[$urandom_range(0, open_seqs.size() - 1)];
                    pkt = mk_pkt(first.side, first.sequence_number, ts);
                end else begin
                    first = done_seqs[$urandom_range(0, done_seqs.size() - 1)];
                    pkt = mk_pkt(1'($urandom_range(0, 1)), first.sequence_number, ts);
                end
            end else if (r < 92) begin
                // new sequence; a narrow pool of slots and tags forces evictions
                if ($urandom_range(0, 99) < 60) seq = {$urandom, $urandom};
                else seq = {54'($urandom_range(0, 3)), 10'($urandom_range(0, 15))};
                pkt = mk_pkt(1'($urandom_range(0, 1)), seq, {$urandom, $urandom});
                open_seqs.push_back(pkt);
                if (open_seqs.size() > 48) void'(open_seqs.pop_front());
            end else begin
                pkt = mk_pkt(1'($urandom_range(0, 1)), {$urandom, $urandom},
                             {$urandom, $urandom});
            end
            packet_queue.push_back(pkt);
        end

        // directed tail: clipped wins drive both sums into saturation
        for (int j = 0; j < 2; j++) begin
            packet_queue.push_back(mk_pkt(1'b0, 64'h5A5A_0000_0000_0000 + j, 64'd0));
            packet_queue.push_back(mk_pkt(1'b1, 64'h5A5A_0000_0000_0000 + j, '1));
        end
        for (int j = 0; j < 3; j++) begin
            packet_queue.push_back(mk_pkt(1'b1, 64'hA5A5_0000_0000_0010 + j, 64'd0));
            packet_queue.push_back(mk_pkt(1'b0, 64'hA5A5_0000_0000_0010 + j, '1));
        end

        // single reset at the start; the block then clears its table by itself
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // drain: all beats taken, all reports seen, then a short quiet spell
        while (packet_queue.size() > 0 || start || report_queue.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d packet beats and %0d checked reports", beat_count,
                 report_count);
        $display("pairs matched %0d, ties %0d, clipped advantages %0d, errors %0d",
                 pair_count, tie_count, clip_count, err_count);
        if (err_count == 0) begin
            $display("PASS dual_feed_latency_matcher");
        end else begin
            $display("FAIL dual_feed_latency_matcher");
        end
        $finish;
    end

endmodule

/* dual_feed_latency_matcher.f */
sv/dfl_pkg.sv
sv/dfl_ctrl.sv
sv/dfl_dpath.sv
sv/dual_feed_latency_matcher.sv
tb/tb_dual_feed_latency_matcher.sv
